[design/gta_pkg.sv]
// Shared types, constants and helper functions of the 8x4 tile accumulate unit.
package gta_pkg;

   localparam int TILE_ROWS = 8;
   localparam int TILE_COLS = 4;
   localparam int ACC_DEPTH = TILE_ROWS * TILE_COLS;
   localparam int ROW_W     = 3;
   localparam int COL_W     = $clog2(TILE_COLS);
   localparam int CNT_W     = $clog2(ACC_DEPTH);

   localparam logic [1:0] FUNC_LOAD_B = 2'd0;
   localparam logic [1:0] FUNC_STEP   = 2'd1;
   localparam logic [1:0] FUNC_FLUSH  = 2'd2;

   localparam logic [63:0] ONE_BITS    = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;
   localparam logic [62:0] INF_MAG     = 63'h7FF0_0000_0000_0000;

   typedef logic [63:0]        dword_type;
   typedef logic signed [13:0] exp_type;

   typedef struct packed {
      logic done;
      logic idle;
   } fma_stat_type;

   function automatic logic is_nan(input dword_type v);
      return v[62:0] > INF_MAG;
   endfunction

   function automatic logic is_inf(input dword_type v);
      return v[62:0] == INF_MAG;
   endfunction

   function automatic logic is_zero(input dword_type v);
      return v[62:0] == 63'd0;
   endfunction

   // Right shift with every dropped bit ORed into bit 0.
   function automatic logic [127:0] shr_sticky(input logic [127:0] x, input logic [13:0] n);
      logic [127:0] r;
      logic [127:0] mask;
      if (n >= 14'd128) begin
         r = {127'd0, |x};
      end else begin
         r    = x >> n[6:0];
         mask = ~({128{1'b1}} << n[6:0]);
         r[0] = r[0] | (|(x & mask));
      end
      return r;
   endfunction

endpackage

[design/gta_channels.sv]
// Handshake channel interfaces for requests and responses.
interface gta_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [2:0] row;
   logic [63:0] x0;
   logic [63:0] x1;
   logic [63:0] x2;
   logic [63:0] x3;
   logic [63:0] x4;
   logic [63:0] x5;
   logic [63:0] x6;
   logic [63:0] x7;

   modport source (output valid, func, row, x0, x1, x2, x3, x4, x5, x6, x7, input ready);
   modport sink (input valid, func, row, x0, x1, x2, x3, x4, x5, x6, x7, output ready);
endinterface

interface gta_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] out_row;
   logic [63:0] sum0;
   logic [63:0] sum1;
   logic [63:0] sum2;
   logic [63:0] sum3;
   logic       is_last;

   modport source (output valid, out_row, sum0, sum1, sum2, sum3, is_last, input ready);
   modport sink (input valid, out_row, sum0, sum1, sum2, sum3, is_last, output ready);
endinterface

[design/gta_acc_cell.sv]
// One accumulator cell of the rotating accumulator chain.
module gta_acc_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  gta_pkg::dword_type  next_val,
   output gta_pkg::dword_type  value
);
   gta_pkg::dword_type value_ff;
   gta_pkg::dword_type value_in;

   always_comb begin
      value_in = value_ff;
      if (advance) begin
         value_in = next_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;
endmodule

[design/gta_fma.sv]
// Iterative binary64 fused multiply-add, round to nearest even.
module gta_fma (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  gta_pkg::dword_type     x_in,
   input  gta_pkg::dword_type     y_in,
   input  gta_pkg::dword_type     z_in,
   output gta_pkg::fma_stat_type  stat,
   output gta_pkg::dword_type     result
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_NORM  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_ALIGN = 3'd3;
   localparam logic [2:0] S_ADD   = 3'd4;
   localparam logic [2:0] S_LZ    = 3'd5;
   localparam logic [2:0] S_RND   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]   state_ff, state_in;
   logic [52:0]  mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;
   gta_pkg::exp_type ex_ff, ex_in, ey_ff, ey_in, ez_ff, ez_in, e_ff, e_in;
   logic         sp_ff, sp_in, sz_ff, sz_in, zzero_ff, zzero_in, sign_ff, sign_in;
   logic [1:0]   mcnt_ff, mcnt_in;
   logic [105:0] prod_ff, prod_in;
   logic [127:0] p_ff, p_in, c_ff, c_in;
   gta_pkg::dword_type res_ff, res_in;

   // start-cycle decode
   logic        s_sp, s_pinf, s_pzero, s_special;
   gta_pkg::dword_type s_res;
   // multiply
   logic [26:0] pa, pb;
   logic [53:0] pp;
   logic [105:0] pp_sh;
   // align
   logic [127:0] pw, cw;
   gta_pkg::exp_type ep, ec, diff;
   // round
   gta_pkg::exp_type lsb, shamt;
   logic [127:0] t;
   logic [53:0]  mant;
   gta_pkg::exp_type be;

   always_comb begin
      s_sp    = x_in[63] ^ y_in[63];
      s_pinf  = gta_pkg::is_inf(x_in) || gta_pkg::is_inf(y_in);
      s_pzero = gta_pkg::is_zero(x_in) || gta_pkg::is_zero(y_in);
      s_special = 1'b1;
      s_res     = '0;
      priority if (gta_pkg::is_nan(x_in) || gta_pkg::is_nan(y_in) || gta_pkg::is_nan(z_in)) begin
         s_res = gta_pkg::DEFAULT_NAN;
      end else if (s_pinf && s_pzero) begin
         s_res = gta_pkg::DEFAULT_NAN;
      end else if (s_pinf) begin
         if (gta_pkg::is_inf(z_in) && (z_in[63] != s_sp)) begin
            s_res = gta_pkg::DEFAULT_NAN;
         end else begin
            s_res = {s_sp, gta_pkg::INF_MAG};
         end
      end else if (gta_pkg::is_inf(z_in)) begin
         s_res = z_in;
      end else if (s_pzero) begin
         if (!gta_pkg::is_zero(z_in)) begin
            s_res = z_in;
         end else begin
            s_res = {(s_sp == z_in[63]) ? s_sp : 1'b0, 63'd0};
         end
      end else begin
         s_special = 1'b0;
      end
   end

   always_comb begin
      pa    = mcnt_ff[0] ? {1'b0, mx_ff[52:27]} : mx_ff[26:0];
      pb    = mcnt_ff[1] ? {1'b0, my_ff[52:27]} : my_ff[26:0];
      pp    = pa * pb;
      pp_sh = {52'd0, pp};
      unique case (mcnt_ff)
         2'd0:    pp_sh = {52'd0, pp};
         2'd3:    pp_sh = {pp[51:0], 54'd0};
         default: pp_sh = {25'd0, pp, 27'd0};
      endcase
   end

   always_comb begin
      pw   = {2'b00, prod_ff, 20'd0};
      cw   = {2'b00, mz_ff, 73'd0};
      ep   = ex_ff + ey_ff - 14'sd20;
      ec   = ez_ff - 14'sd73;
      diff = (ep >= ec) ? (ep - ec) : (ec - ep);
   end

   always_comb begin
      lsb = e_ff + 14'sd75;
      if (lsb < -14'sd1074) begin
         lsb = -14'sd1074;
      end
      shamt = lsb - e_ff - 14'sd2;
      t     = gta_pkg::shr_sticky(p_ff, shamt);
      mant  = t[55:2];
      if (t[1] && (t[0] || mant[0])) begin
         mant = mant + 54'd1;
      end
      if (mant[53]) begin
         mant = mant >> 1;
         lsb  = lsb + 14'sd1;
      end
      be = lsb + 14'sd1075;
   end

   always_comb begin
      state_in = state_ff;
      mx_in = mx_ff; my_in = my_ff; mz_in = mz_ff;
      ex_in = ex_ff; ey_in = ey_ff; ez_in = ez_ff; e_in = e_ff;
      sp_in = sp_ff; sz_in = sz_ff; zzero_in = zzero_ff; sign_in = sign_ff;
      mcnt_in = mcnt_ff; prod_in = prod_ff; p_in = p_ff; c_in = c_ff; res_in = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               sp_in    = s_sp;
               sz_in    = z_in[63];
               zzero_in = gta_pkg::is_zero(z_in);
               mx_in = {x_in[62:52] != 11'd0, x_in[51:0]};
               my_in = {y_in[62:52] != 11'd0, y_in[51:0]};
               mz_in = {z_in[62:52] != 11'd0, z_in[51:0]};
               ex_in = (x_in[62:52] == 11'd0) ? -14'sd1074
                                              : $signed({3'b000, x_in[62:52]}) - 14'sd1075;
               ey_in = (y_in[62:52] == 11'd0) ? -14'sd1074
                                              : $signed({3'b000, y_in[62:52]}) - 14'sd1075;
               ez_in = (z_in[62:52] == 11'd0) ? -14'sd1074
                                              : $signed({3'b000, z_in[62:52]}) - 14'sd1075;
               mcnt_in = '0;
               prod_in = '0;
               res_in  = s_res;
               state_in = s_special ? S_DONE : S_NORM;
            end
         end
         S_NORM: begin
            // bring subnormal significands up to the hidden bit, one bit a cycle
            if (!mx_ff[52]) begin
               mx_in = mx_ff << 1;
               ex_in = ex_ff - 14'sd1;
            end
            if (!my_ff[52]) begin
               my_in = my_ff << 1;
               ey_in = ey_ff - 14'sd1;
            end
            if (!mz_ff[52] && !zzero_ff) begin
               mz_in = mz_ff << 1;
               ez_in = ez_ff - 14'sd1;
            end
            if (mx_ff[52] && my_ff[52] && (mz_ff[52] || zzero_ff)) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = prod_ff + pp_sh;
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd3) begin
               state_in = S_ALIGN;
            end
         end
         S_ALIGN: begin
            if (zzero_ff) begin
               p_in = pw; e_in = ep; sign_in = sp_ff;
               state_in = S_LZ;
            end else if (ep >= ec) begin
               p_in = pw; c_in = gta_pkg::shr_sticky(cw, diff); e_in = ep;
               state_in = S_ADD;
            end else begin
               p_in = gta_pkg::shr_sticky(pw, diff); c_in = cw; e_in = ec;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            state_in = S_LZ;
            priority if (sp_ff == sz_ff) begin
               p_in = p_ff + c_ff; sign_in = sp_ff;
            end else if (p_ff == c_ff) begin
               res_in = '0;
               state_in = S_DONE;
            end else if (p_ff > c_ff) begin
               p_in = p_ff - c_ff; sign_in = sp_ff;
            end else begin
               p_in = c_ff - p_ff; sign_in = sz_ff;
            end
         end
         S_LZ: begin
            priority if (p_ff[127:120] == 8'd0) begin
               p_in = p_ff << 8; e_in = e_ff - 14'sd8;
            end else if (!p_ff[127]) begin
               p_in = p_ff << 1; e_in = e_ff - 14'sd1;
            end else begin
               state_in = S_RND;
            end
         end
         S_RND: begin
            if (mant[52]) begin
               if (be >= 14'sd2047) begin
                  res_in = {sign_ff, gta_pkg::INF_MAG};
               end else begin
                  res_in = {sign_ff, be[10:0], mant[51:0]};
               end
            end else begin
               res_in = {sign_ff, 11'd0, mant[51:0]};
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mx_ff <= mx_in; my_ff <= my_in; mz_ff <= mz_in;
      ex_ff <= ex_in; ey_ff <= ey_in; ez_ff <= ez_in; e_ff <= e_in;
      sp_ff <= sp_in; sz_ff <= sz_in; zzero_ff <= zzero_in; sign_ff <= sign_in;
      mcnt_ff <= mcnt_in; prod_ff <= prod_in; p_ff <= p_in; c_ff <= c_in; res_ff <= res_in;
   end

   assign stat.done = (state_ff == S_DONE);
   assign stat.idle = (state_ff == S_IDLE);
   assign result    = res_ff;

`ifndef SYNTHESIS
   a_norm_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NORM && state_in == S_MUL) |-> (mx_ff[52] && my_ff[52]))
      else $error("multiply entered with unnormalized significand");
   a_lz_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RND) |-> p_ff[127])
      else $error("rounding entered with unnormalized sum");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> (state_ff == S_IDLE))
      else $error("done held longer than one cycle");
`endif
endmodule

[design/gemm_tile_8x4_accumulate_unit.sv]
// Top level: 8x4 binary64 tile accumulate with a rotating accumulator chain.
//
//   channel | dir | beat contents
//   req_bus | in  | func, row, x0..x7 (B row, A column or C row)
//   rsp_bus | out | out_row, sum0..sum3, is_last (one beat per flushed row)
//
// A B-row load is written straight into B while idle. An A step rotates all 32 accumulator
// cells once, the single shared FMA serving each cell in turn; NaN, infinity or zero
// operands skip straight to the result, while subnormal operands or deep cancellation
// add normalization steps. A flush rotates the chain once, FMA only on the four cells
// of the row: 28 plain moves plus four FMAs.
// Reset clears B and all accumulators to +0; no new beat is taken
// until the previous one is finished and its response has been taken.
module gemm_tile_8x4_accumulate_unit (
   input logic clock,
   input logic reset,
   gta_req_if.sink   req_bus,
   gta_rsp_if.source rsp_bus
);
   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_RUN  = 2'd1;
   localparam logic [1:0] T_OUT  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [gta_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic flush_ff, flush_in, issued_ff, issued_in;
   logic [gta_pkg::ROW_W-1:0] row_ff, row_in;
   gta_pkg::dword_type a_ff [8];
   gta_pkg::dword_type b_ff [gta_pkg::TILE_COLS];
   gta_pkg::dword_type sum_ff [4];

   gta_pkg::dword_type cell_val [gta_pkg::ACC_DEPTH];
   gta_pkg::dword_type tail_val;
   logic advance, need, accept, fma_start;
   logic [2:0] a_idx;
   gta_pkg::dword_type fma_x, fma_res;
   gta_pkg::fma_stat_type fma_stat;

   for (genvar k = 0; k < gta_pkg::ACC_DEPTH; k++) begin : g_cell
      gta_pkg::dword_type nxt;
      if (k == gta_pkg::ACC_DEPTH - 1) begin : g_tail
         assign nxt = tail_val;
      end else begin : g_mid
         assign nxt = cell_val[k+1];
      end
      gta_acc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .next_val (nxt),
         .value    (cell_val[k])
      );
   end

   assign accept = req_bus.valid && req_bus.ready;
   assign need   = !flush_ff || (cnt_ff[gta_pkg::CNT_W-1:gta_pkg::COL_W] == row_ff);
   assign a_idx  = flush_ff ? {1'b0, cnt_ff[gta_pkg::COL_W-1:0]}
                            : cnt_ff[gta_pkg::CNT_W-1:gta_pkg::COL_W];
   assign fma_x  = a_ff[a_idx];

   gta_fma u_fma (
      .clock  (clock),
      .reset  (reset),
      .start  (fma_start),
      .x_in   (fma_x),
      .y_in   (flush_ff ? gta_pkg::ONE_BITS : b_ff[cnt_ff[gta_pkg::COL_W-1:0]]),
      .z_in   (cell_val[0]),
      .stat   (fma_stat),
      .result (fma_res)
   );

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      flush_in  = flush_ff;
      issued_in = issued_ff;
      row_in    = row_ff;
      advance   = 1'b0;
      fma_start = 1'b0;
      tail_val  = cell_val[0];
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               if (req_bus.func == gta_pkg::FUNC_STEP) begin
                  flush_in = 1'b0;
                  state_in = T_RUN;
               end else if (req_bus.func == gta_pkg::FUNC_FLUSH &&
                            int'(req_bus.row) < gta_pkg::TILE_ROWS) begin
                  flush_in = 1'b1;
                  row_in   = req_bus.row;
                  state_in = T_RUN;
               end
            end
         end
         T_RUN: begin
            if (need) begin
               if (!issued_ff) begin
                  fma_start = 1'b1;
                  issued_in = 1'b1;
               end else if (fma_stat.done) begin
                  advance   = 1'b1;
                  issued_in = 1'b0;
                  tail_val  = flush_ff ? '0 : fma_res;
               end
            end else begin
               advance = 1'b1;
            end
            if (advance) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == gta_pkg::CNT_W'(gta_pkg::ACC_DEPTH - 1)) begin
                  state_in = flush_ff ? T_OUT : T_IDLE;
               end
            end
         end
         T_OUT: begin
            if (rsp_bus.ready) begin
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= T_IDLE;
         cnt_ff    <= '0;
         issued_ff <= 1'b0;
         flush_ff  <= 1'b0;
         for (int j = 0; j < gta_pkg::TILE_COLS; j++) begin
            b_ff[j] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         issued_ff <= issued_in;
         flush_ff  <= flush_in;
         if (accept && req_bus.func == gta_pkg::FUNC_LOAD_B) begin
            b_ff[0] <= req_bus.x0; b_ff[1] <= req_bus.x1;
            b_ff[2] <= req_bus.x2; b_ff[3] <= req_bus.x3;
         end
      end
      row_ff <= row_in;
      if (accept) begin
         a_ff[0] <= req_bus.x0; a_ff[1] <= req_bus.x1;
         a_ff[2] <= req_bus.x2; a_ff[3] <= req_bus.x3;
         a_ff[4] <= req_bus.x4; a_ff[5] <= req_bus.x5;
         a_ff[6] <= req_bus.x6; a_ff[7] <= req_bus.x7;
      end
      // capture the flushed column as its cell leaves the head
      if (advance && flush_ff && need) begin
         sum_ff[cnt_ff[gta_pkg::COL_W-1:0]] <= fma_res;
      end
   end

   assign req_bus.ready   = (state_ff == T_IDLE);
   assign rsp_bus.valid   = (state_ff == T_OUT);
   assign rsp_bus.out_row = row_ff;
   assign rsp_bus.sum0    = sum_ff[0];
   assign rsp_bus.sum1    = sum_ff[1];
   assign rsp_bus.sum2    = sum_ff[2];
   assign rsp_bus.sum3    = sum_ff[3];
   assign rsp_bus.is_last = (row_ff == gta_pkg::ROW_W'(gta_pkg::TILE_ROWS - 1));

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      fma_start |-> fma_stat.idle)
      else $error("FMA started while busy");
   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      fma_stat.done |-> issued_ff)
      else $error("FMA result without an issued operation");
   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_IDLE) |-> (cnt_ff == '0 && !issued_ff))
      else $error("chain not back at its origin when idle");
   a_step_run: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.func == gta_pkg::FUNC_STEP) |=> (state_ff == T_RUN))
      else $error("A step did not start a rotation");
`endif
endmodule

[test/testbench.sv]
// Self-checking testbench of the 8x4 binary64 tile accumulate unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef gta_pkg::dword_type lanes_type [8];

   typedef struct {
      logic [2:0]         out_row;
      gta_pkg::dword_type sum [4];
      logic               is_last;
   } row_sums_type;

   localparam logic [1:0]         FUNC_UNUSED = 2'd3;
   localparam gta_pkg::dword_type POS_INF     = 64'h7FF0_0000_0000_0000;
   localparam gta_pkg::dword_type NEG_INF     = 64'hFFF0_0000_0000_0000;
   localparam gta_pkg::dword_type NEG_ZERO    = 64'h8000_0000_0000_0000;
   localparam gta_pkg::dword_type MAX_NORM    = 64'h7FEF_FFFF_FFFF_FFFF;
   localparam gta_pkg::dword_type MIN_NORM    = 64'h0010_0000_0000_0000;
   localparam gta_pkg::dword_type MIN_SUB     = 64'h0000_0000_0000_0001;
   localparam gta_pkg::dword_type TWO_BITS    = 64'h4000_0000_0000_0000;
   localparam gta_pkg::dword_type NEG_ONE     = 64'hBFF0_0000_0000_0000;
   localparam gta_pkg::dword_type SIG_NAN     = 64'h7FF0_0000_0000_0001;
   localparam int                 CYCLE_LIMIT = 20_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   gta_req_if req_bus ();
   gta_rsp_if rsp_bus ();

   gemm_tile_8x4_accumulate_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #5 clock = ~clock;

   gta_pkg::dword_type b_vals [gta_pkg::TILE_COLS];
   gta_pkg::dword_type acc_vals [gta_pkg::ACC_DEPTH];
   row_sums_type       pending_rows [$];
   int                 errors = 0;
   int                 beats_sent = 0;
   int                 steps_sent = 0;
   int                 rows_checked = 0;
   int                 cycles = 0;
   int                 hold_cycles = 0;
   bit                 idle_on = 1'b1;

   // ---------------- binary64 arithmetic ----------------
   function automatic logic [127:0] sticky_shift(input logic [127:0] x, input int n);
      logic [127:0] r;
      if (n <= 0) return x;
      if (n >= 128) return {127'd0, |x};
      r = x >> n;
      if (|(x & ~({128{1'b1}} << n))) r[0] = 1'b1;
      return r;
   endfunction

   function automatic int top_bit(input logic [127:0] x);
      for (int i = 127; i > 0; i--)
         if (x[i]) return i;
      return 0;
   endfunction

   function automatic void split(input gta_pkg::dword_type v, output logic [63:0] m,
                                 output int e);
      if (v[62:52] == 11'd0) begin
         m = {12'd0, v[51:0]};
         e = -1074;
         while (!m[52]) begin
            m = m << 1;
            e--;
         end
      end else begin
         m = {11'd0, 1'b1, v[51:0]};
         e = int'(v[62:52]) - 1075;
      end
   endfunction

   function automatic gta_pkg::dword_type round_even(input logic sgn, input logic [127:0] r,
                                                     input int e);
      int          lsb, s, be;
      logic [63:0] mant;
      logic [127:0] t;
      logic        rnd, stk;
      rnd = 1'b0;
      stk = 1'b0;
      lsb = top_bit(r) + e - 52;
      if (lsb < -1074) lsb = -1074;
      s = lsb - e;
      if (s <= 0) begin
         t = r << (-s);
         mant = t[63:0];
      end else begin
         t = (s >= 128) ? 128'd0 : r >> s;
         mant = t[63:0];
         rnd = (s - 1 < 128) ? r[s-1] : 1'b0;
         stk = (s - 1 >= 128) ? |r : |(r & ~({128{1'b1}} << (s - 1)));
      end
      if (rnd && (stk || mant[0])) mant++;
      if (mant[53]) begin
         mant = mant >> 1;
         lsb++;
      end
      if (mant[52]) begin
         be = lsb + 1075;
         if (be >= 2047) return {sgn, POS_INF[62:0]};
         return {sgn, be[10:0], mant[51:0]};
      end
      return {sgn, mant[62:0]};
   endfunction

   // x*y + z, one rounding
   function automatic gta_pkg::dword_type fma64(input gta_pkg::dword_type x,
                                                input gta_pkg::dword_type y,
                                                input gta_pkg::dword_type z);
      logic         sp, sz, sgn, pinf, pzero;
      logic [63:0]  mx, my, mz;
      int           ex, ey, ez, ep, ec, e;
      logic [127:0] p, c, r;
      sp = x[63] ^ y[63];
      sz = z[63];
      pinf = (x[62:0] == POS_INF[62:0]) || (y[62:0] == POS_INF[62:0]);
      pzero = (x[62:0] == 63'd0) || (y[62:0] == 63'd0);
      if (x[62:0] > POS_INF[62:0] || y[62:0] > POS_INF[62:0] || z[62:0] > POS_INF[62:0])
         return gta_pkg::DEFAULT_NAN;
      if (pinf && pzero) return gta_pkg::DEFAULT_NAN;
      if (pinf) begin
         if (z[62:0] == POS_INF[62:0] && sz != sp) return gta_pkg::DEFAULT_NAN;
         return {sp, POS_INF[62:0]};
      end
      if (z[62:0] == POS_INF[62:0]) return z;
      if (pzero) begin
         if (z[62:0] != 63'd0) return z;
         return (sp == sz) ? {sp, 63'd0} : 64'd0;
      end
      split(x, mx, ex);
      split(y, my, ey);
      p = (128'(mx) * 128'(my)) << 20;
      ep = ex + ey - 20;
      if (z[62:0] == 63'd0) return round_even(sp, p, ep);
      split(z, mz, ez);
      c = 128'(mz) << 73;
      ec = ez - 73;
      if (ep >= ec) begin
         c = sticky_shift(c, ep - ec);
         e = ep;
      end else begin
         p = sticky_shift(p, ec - ep);
         e = ec;
      end
      if (sp == sz) begin
         r = p + c;
         sgn = sp;
      end else if (p == c) begin
         return 64'd0;
      end else if (p > c) begin
         r = p - c;
         sgn = sp;
      end else begin
         r = c - p;
         sgn = sz;
      end
      return round_even(sgn, r, e);
   endfunction

   // Advance the tile state by one accepted beat; queue the row sums it yields.
   function automatic void update_tile(input logic [1:0] f, input logic [2:0] r,
                                       input lanes_type v);
      row_sums_type rs;
      case (f)
         gta_pkg::FUNC_LOAD_B: begin
            for (int j = 0; j < gta_pkg::TILE_COLS; j++) b_vals[j] = v[j];
         end
         gta_pkg::FUNC_STEP: begin
            for (int i = 0; i < gta_pkg::TILE_ROWS; i++)
               for (int j = 0; j < gta_pkg::TILE_COLS; j++)
                  acc_vals[i*gta_pkg::TILE_COLS+j] =
                     fma64(v[i], b_vals[j], acc_vals[i*gta_pkg::TILE_COLS+j]);
         end
         gta_pkg::FUNC_FLUSH: begin
            rs.out_row = r;
            for (int j = 0; j < 4; j++) begin
               rs.sum[j] = fma64(v[j], gta_pkg::ONE_BITS, acc_vals[r*gta_pkg::TILE_COLS+j]);
               acc_vals[r*gta_pkg::TILE_COLS+j] = 64'd0;
            end
            rs.is_last = (r == 3'(gta_pkg::TILE_ROWS - 1));
            pending_rows.push_back(rs);
         end
         default: ;
      endcase
   endfunction

   // ---------------- stimulus ----------------
   function automatic int gap_cycles();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
   endfunction

   function automatic gta_pkg::dword_type rand_f64();
      logic s;
      s = $urandom_range(0, 1);
      case ($urandom_range(0, 15))
         0: return {s, 63'd0};
         1: return {s, POS_INF[62:0]};
         2: return {s, 11'h7FF, 20'($urandom) | 20'd1, 32'($urandom)};
         3: return {s, 11'd0, 20'($urandom), 32'($urandom)};
         4, 5: return {32'($urandom), 32'($urandom)};
         6: return {s, ($urandom_range(0, 1) != 0) ? MAX_NORM[62:0] : MIN_NORM[62:0]};
         7: return {s, 11'($urandom_range(1, 60)), 20'($urandom), 32'($urandom)};
         8: return {s, 11'($urandom_range(1990, 2046)), 20'($urandom), 32'($urandom)};
         default: return {s, 11'($urandom_range(1018, 1028)), 20'($urandom), 32'($urandom)};
      endcase
   endfunction

   function automatic lanes_type rand_lanes();
      lanes_type v;
      foreach (v[i]) v[i] = rand_f64();
      return v;
   endfunction

   task automatic send_beat(input logic [1:0] f, input logic [2:0] r, input lanes_type v);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap_cycles()) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func  <= f;
      req_bus.row   <= r;
      req_bus.x0 <= v[0]; req_bus.x1 <= v[1]; req_bus.x2 <= v[2]; req_bus.x3 <= v[3];
      req_bus.x4 <= v[4]; req_bus.x5 <= v[5]; req_bus.x6 <= v[6]; req_bus.x7 <= v[7];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      update_tile(f, r, v);
      beats_sent++;
      if (f == gta_pkg::FUNC_STEP) steps_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
   endtask

   task automatic test_special_values();
      lanes_type v;
      v = rand_lanes();
      v[0] = gta_pkg::ONE_BITS; v[1] = NEG_ZERO; v[2] = POS_INF; v[3] = MAX_NORM;
      send_beat(gta_pkg::FUNC_LOAD_B, 3'($urandom), v);
      // zero times infinity, NaN input, overflow, tiny products
      v = '{64'd0, gta_pkg::ONE_BITS, TWO_BITS, SIG_NAN, NEG_INF, MIN_SUB, NEG_ONE, MAX_NORM};
      send_beat(gta_pkg::FUNC_STEP, 3'($urandom), v);
      send_beat(FUNC_UNUSED, 3'($urandom), rand_lanes());
      for (int r = 0; r < gta_pkg::TILE_ROWS; r++) begin
         v = rand_lanes();
         if (r == 1) begin
            v[0] = NEG_ONE; v[1] = NEG_ZERO; v[2] = NEG_INF; v[3] = 64'd0;
         end
         if (r == 6) begin
            v[0] = gta_pkg::ONE_BITS; v[1] = 64'd0; v[2] = POS_INF; v[3] = NEG_INF;
         end
         send_beat(gta_pkg::FUNC_FLUSH, 3'(r), v);
      end
      v = rand_lanes();
      v[0] = MIN_SUB;
      v[1] = 64'h8010_0000_0000_0000;
      v[2] = 64'h3FF8_0000_0000_0000;
      v[3] = 64'hFFEF_FFFF_FFFF_FFFF;
      send_beat(gta_pkg::FUNC_LOAD_B, 3'($urandom), v);
      v = '{64'h3FE0_0000_0000_0000, NEG_ZERO, MIN_NORM, NEG_ONE, 64'h0008_0000_0000_0000,
            MAX_NORM, gta_pkg::ONE_BITS, 64'h4340_0000_0000_0000};
      send_beat(gta_pkg::FUNC_STEP, 3'($urandom), v);
      send_beat(gta_pkg::FUNC_FLUSH, 3'd0, '{8{NEG_ZERO}});
      send_beat(gta_pkg::FUNC_FLUSH, 3'd5, rand_lanes());
      send_beat(gta_pkg::FUNC_FLUSH, 3'd7, '{8{64'd0}});
   endtask

   task automatic test_random_tiles(input int n_beats);
      int k;
      while (beats_sent < n_beats) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: stray beat of any kind
            send_beat(2'($urandom), 3'($urandom), rand_lanes());
            continue;
         end
         k = $urandom_range(1, 3);
         repeat (k) begin
            send_beat(gta_pkg::FUNC_LOAD_B, 3'($urandom), rand_lanes());
            send_beat(gta_pkg::FUNC_STEP, 3'($urandom), rand_lanes());
         end
         if ($urandom_range(0, 2) != 0)
            for (int r = 0; r < gta_pkg::TILE_ROWS; r++)
               send_beat(gta_pkg::FUNC_FLUSH, 3'(r), rand_lanes());
         else
            repeat ($urandom_range(1, 4))
               send_beat(gta_pkg::FUNC_FLUSH, 3'($urandom), rand_lanes());
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 600;
      for (int r = 0; r < gta_pkg::TILE_ROWS; r++)
         send_beat(gta_pkg::FUNC_FLUSH, 3'(r), rand_lanes());
      wait_drained();
   endtask

   task automatic test_no_idle();
      idle_on = 1'b0;
      send_beat(gta_pkg::FUNC_LOAD_B, 3'($urandom), rand_lanes());
      send_beat(gta_pkg::FUNC_STEP, 3'($urandom), rand_lanes());
      for (int r = 0; r < gta_pkg::TILE_ROWS; r++)
         send_beat(gta_pkg::FUNC_FLUSH, 3'(r), rand_lanes());
      wait_drained();
      idle_on = 1'b1;
   endtask

   // ---------------- result checking ----------------
   initial begin
      int stall;
      row_sums_type exp_row;
      stall = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_rows.size() == 0) begin
               $error("unexpected row beat, out_row %0d", rsp_bus.out_row);
               errors++;
            end else begin
               exp_row = pending_rows.pop_front();
               rows_checked++;
               if (rsp_bus.out_row !== exp_row.out_row) begin
                  $error("out_row expected %0d actual %0d", exp_row.out_row, rsp_bus.out_row);
                  errors++;
               end
               if (rsp_bus.sum0 !== exp_row.sum[0]) begin
                  $error("sum0 expected %h actual %h", exp_row.sum[0], rsp_bus.sum0);
                  errors++;
               end
               if (rsp_bus.sum1 !== exp_row.sum[1]) begin
                  $error("sum1 expected %h actual %h", exp_row.sum[1], rsp_bus.sum1);
                  errors++;
               end
               if (rsp_bus.sum2 !== exp_row.sum[2]) begin
                  $error("sum2 expected %h actual %h", exp_row.sum[2], rsp_bus.sum2);
                  errors++;
               end
               if (rsp_bus.sum3 !== exp_row.sum[3]) begin
                  $error("sum3 expected %h actual %h", exp_row.sum[3], rsp_bus.sum3);
                  errors++;
               end
               if (rsp_bus.is_last !== exp_row.is_last) begin
                  $error("is_last expected %0b actual %0b", exp_row.is_last, rsp_bus.is_last);
                  errors++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall = gap_cycles() - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.func  <= gta_pkg::FUNC_LOAD_B;
      req_bus.row   <= 3'd0;
      req_bus.x0 <= '0; req_bus.x1 <= '0; req_bus.x2 <= '0; req_bus.x3 <= '0;
      req_bus.x4 <= '0; req_bus.x5 <= '0; req_bus.x6 <= '0; req_bus.x7 <= '0;
      foreach (b_vals[j]) b_vals[j] = 64'd0;
      foreach (acc_vals[i]) acc_vals[i] = 64'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_values();
      test_backpressure();
      test_random_tiles(400);
      wait_drained();
      test_no_idle();
      test_random_tiles(780);
      for (int r = 0; r < gta_pkg::TILE_ROWS; r++)
         send_beat(gta_pkg::FUNC_FLUSH, 3'(r), rand_lanes());
      wait_drained();
      repeat (3000) @(posedge clock);
      $display("covered %0d beats (%0d A steps), %0d row sums checked", beats_sent,
               steps_sent, rows_checked);
      $display("special operands, stray func codes, long output stalls and drain pauses");
      if (errors == 0 && pending_rows.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
